@@ rtl/core/rvx_pkg.sv @@
// Shared types, opcodes and sizes for the RV32IM execute block.
package rvx_pkg;

  localparam int DataAw     = 12;
  localparam int DATA_WORDS = 1 << DataAw;

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_IO     = 7'b0001011;
  localparam logic [6:0] F7_ALT     = 7'b0100000;
  localparam logic [6:0] F7_MUL     = 7'b0000001;

  localparam logic [2:0] F3_B    = 3'd0;
  localparam logic [2:0] F3_H    = 3'd1;
  localparam logic [2:0] F3_W    = 3'd2;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_HU   = 3'd5;
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU = 3'd3;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_REMU = 3'd7;

  typedef enum logic [3:0] {
    CL_HALT, CL_IO, CL_LUI, CL_AUIPC, CL_JAL, CL_JALR, CL_BRANCH,
    CL_LOAD, CL_STORE, CL_OPIMM, CL_OP, CL_MULDIV, CL_ILL
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_LOAD, ST_MUL, ST_DIV, ST_DONE
  } state_e;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] imm;
    logic [7:0]  ch;
    logic [6:0]  f7;
    logic [4:0]  rs2;
    logic [4:0]  rs1;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        w12;
    logic        w14;
  } dec_t;

endpackage

@@ rtl/core/rv32im_instruction_execute.sv @@
// Top level of the RV32IM execute block: front decoder, queue and back end.
//  channel | direction | valid       | stall       | words
//  input   | in        | in_valid_i  | in_stall_o  | instr_word_i, in_char_i
//  result  | out       | res_valid_o | res_stall_i | next_pc_o .. wb_value_o
// One instruction is in execution at a time: ALU ops pass through states EXEC and DONE,
// loads and multiplies also through LOAD or MUL, div/rem through DIV (serial divider).
// After reset all 4096 data words are zeroed one word per cycle, with in_stall_o high.
// A two-entry queue keeps taking words while the back end works or the result is stalled.
module rv32im_instruction_execute import rvx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_word_i,
  input  logic [7:0]  in_char_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [31:0] next_pc_o,
  output logic        halted_o,
  output logic        illegal_o,
  output logic        out_valid_o,
  output logic [7:0]  out_char_o,
  output logic        wb_valid_o,
  output logic [4:0]  wb_index_o,
  output logic [31:0] wb_value_o
);
  dec_t q_head;
  logic q_vld, pop, clr_busy;

  rvx_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .instr_word_i, .in_char_i,
    .clr_busy_i(clr_busy), .pop_i(pop), .q_vld_o(q_vld), .q_head_o(q_head)
  );

  rvx_back u_back (
    .clk_i, .rst_ni, .q_vld_i(q_vld), .q_head_i(q_head), .pop_o(pop),
    .clr_busy_o(clr_busy), .res_valid_o, .res_stall_i, .next_pc_o, .halted_o,
    .illegal_o, .out_valid_o, .out_char_o, .wb_valid_o, .wb_index_o, .wb_value_o
  );
endmodule

@@ rtl/core/rvx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ rtl/core/rvx_front.sv @@
// Front end: accepts instruction words, decodes them and queues them for the back end.
module rvx_front import rvx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_word_i,
  input  logic [7:0]  in_char_i,
  input  logic        clr_busy_i,
  input  logic        pop_i,
  output logic        q_vld_o,
  output dec_t        q_head_o
);
  dec_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  dec_t       dec;
  logic       push;
  logic [6:0] opc;
  logic [31:0] w;

  assign w   = instr_word_i;
  assign opc = w[6:0];

  always_comb begin
    dec.ch  = in_char_i;
    dec.f7  = w[31:25];
    dec.rs2 = w[24:20];
    dec.rs1 = w[19:15];
    dec.f3  = w[14:12];
    dec.rd  = w[11:7];
    dec.w12 = w[12];
    dec.w14 = w[14];
    dec.imm = {{20{w[31]}}, w[31:20]};
    dec.cls = CL_ILL;
    if (w == 32'd0) begin
      dec.cls = CL_HALT;
    end else begin
      case (opc)
        OPC_IO:     dec.cls = CL_IO;
        OPC_LUI: begin
          dec.cls = CL_LUI;
          dec.imm = {w[31:12], 12'd0};
        end
        OPC_AUIPC: begin
          dec.cls = CL_AUIPC;
          dec.imm = {w[31:12], 12'd0};
        end
        OPC_JAL: begin
          dec.cls = CL_JAL;
          dec.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        end
        OPC_JALR:   dec.cls = (w[14:12] == 3'd0) ? CL_JALR : CL_ILL;
        OPC_BRANCH: begin
          dec.cls = CL_BRANCH;
          dec.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        end
        OPC_LOAD:   dec.cls = CL_LOAD;
        OPC_STORE: begin
          dec.cls = CL_STORE;
          dec.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        OPC_OPIMM:  dec.cls = CL_OPIMM;
        OPC_OP:     dec.cls = (w[31:25] == F7_MUL) ? CL_MULDIV : CL_OP;
        default:    dec.cls = CL_ILL;
      endcase
    end
  end

  assign in_stall_o = (cnt_q == 2'd2) || clr_busy_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_vld_o    = (cnt_q != 2'd0);
  assign q_head_o   = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end
endmodule

@@ rtl/core/rvx_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module rvx_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q, rem_q, dvs_q;
  logic [32:0] shifted, diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 32'd0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

@@ rtl/core/rvx_back.sv @@
// Back end: register file, data store, ALU, multiplier, divider and the result register.
module rvx_back import rvx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_vld_i,
  input  dec_t        q_head_i,
  output logic        pop_o,
  output logic        clr_busy_o,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [31:0] next_pc_o,
  output logic        halted_o,
  output logic        illegal_o,
  output logic        out_valid_o,
  output logic [7:0]  out_char_o,
  output logic        wb_valid_o,
  output logic [4:0]  wb_index_o,
  output logic [31:0] wb_value_o
);
  state_e state_q, state_d;
  dec_t   cur_q;
  logic [31:0] pc_q, res_q, res_d, npc_q, npc_d;
  logic        wr_q, wr_d, halt_q, halt_d, ill_q, ill_d, ov_q, ov_d;
  logic [7:0]  och_q, och_d;
  logic        st_en_q, st_en_d;
  logic [DataAw-1:0] st_addr_q, st_addr_d;
  logic [31:0] st_data_q, st_data_d, opa_q, opb_q;
  logic signed [32:0] mul_a_q, mul_b_q, mul_a_d, mul_b_d;
  logic signed [65:0] prod;
  logic [31:0] rf_vld_q;
  logic [DataAw:0] clr_q;
  logic        out_full_q, commit, clr_busy;
  logic [31:0] rd1, rd2, a, b, ea, mrd;
  logic [31:0] dvd, dvs, quo, rem;
  logic        div_start, div_done, na, nb, rf_we, d_re, d_we;
  logic [DataAw-1:0] d_waddr;
  logic [31:0] d_wdata;

  assign clr_busy   = !clr_q[DataAw];
  assign clr_busy_o = clr_busy;
  assign pop_o      = (state_q == ST_IDLE) && q_vld_i && !clr_busy;
  assign commit     = (state_q == ST_DONE) && (!out_full_q || !res_stall_i);
  assign rf_we      = commit && wr_q && (cur_q.rd != 5'd0);

  rvx_ram #(.Width(32), .Depth(32)) u_rf1 (
    .clk_i, .we_i(rf_we), .waddr_i(cur_q.rd), .wdata_i(res_q),
    .re_i(pop_o), .raddr_i(q_head_i.rs1), .rdata_o(rd1)
  );
  rvx_ram #(.Width(32), .Depth(32)) u_rf2 (
    .clk_i, .we_i(rf_we), .waddr_i(cur_q.rd), .wdata_i(res_q),
    .re_i(pop_o), .raddr_i(q_head_i.rs2), .rdata_o(rd2)
  );

  // never-written registers read as zero
  assign a  = rf_vld_q[cur_q.rs1] ? rd1 : 32'd0;
  assign b  = rf_vld_q[cur_q.rs2] ? rd2 : 32'd0;
  assign ea = a + cur_q.imm;

  assign d_re    = (state_q == ST_EXEC);
  assign d_we    = clr_busy || (commit && st_en_q);
  assign d_waddr = clr_busy ? clr_q[DataAw-1:0] : st_addr_q;
  assign d_wdata = clr_busy ? 32'd0 : st_data_q;

  rvx_ram #(.Width(32), .Depth(DATA_WORDS)) u_dmem (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(d_re), .raddr_i(ea[DataAw-1:0]), .rdata_o(mrd)
  );

  assign na        = a[31] && !cur_q.f3[0];
  assign nb        = b[31] && !cur_q.f3[0];
  assign dvd       = na ? (32'd0 - a) : a;
  assign dvs       = nb ? (32'd0 - b) : b;
  assign div_start = (state_q == ST_EXEC) && (cur_q.cls == CL_MULDIV) && cur_q.f3[2];

  rvx_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  assign prod = mul_a_q * mul_b_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop_o) state_d = ST_EXEC;
      ST_EXEC: begin
        case (cur_q.cls)
          CL_LOAD:   state_d = ST_LOAD;
          CL_MULDIV: state_d = cur_q.f3[2] ? ST_DIV : ST_MUL;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_LOAD: state_d = ST_DONE;
      ST_MUL:  state_d = ST_DONE;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    res_d = res_q; wr_d = wr_q; npc_d = npc_q; halt_d = halt_q; ill_d = ill_q;
    ov_d = ov_q; och_d = och_q; st_en_d = st_en_q; st_addr_d = st_addr_q;
    st_data_d = st_data_q; mul_a_d = mul_a_q; mul_b_d = mul_b_q;
    case (state_q)
      ST_EXEC: begin
        res_d = 32'd0; wr_d = 1'b0; npc_d = pc_q + 32'd4; halt_d = 1'b0;
        ill_d = 1'b0; ov_d = 1'b0; och_d = 8'd0; st_en_d = 1'b0;
        st_addr_d = ea[DataAw-1:0]; st_data_d = b;
        mul_a_d = {a[31] && (cur_q.f3 == F3_MULH || cur_q.f3 == F3_MULHSU), a};
        mul_b_d = {b[31] && (cur_q.f3 == F3_MULH), b};
        case (cur_q.cls)
          CL_HALT: begin
            halt_d = 1'b1; npc_d = pc_q;
          end
          CL_ILL: begin
            ill_d = 1'b1; npc_d = pc_q;
          end
          CL_IO: begin
            if (!cur_q.w12) begin
              res_d = cur_q.w14 ? {24'd0, cur_q.ch} : {{24{cur_q.ch[7]}}, cur_q.ch};
              wr_d  = 1'b1;
            end else begin
              ov_d = 1'b1; och_d = a[7:0];
            end
          end
          CL_LUI: begin
            res_d = cur_q.imm; wr_d = 1'b1;
          end
          CL_AUIPC: begin
            res_d = cur_q.imm + pc_q; wr_d = 1'b1;
          end
          CL_JAL: begin
            res_d = pc_q + 32'd4; wr_d = 1'b1; npc_d = pc_q + cur_q.imm;
          end
          CL_JALR: begin
            res_d = pc_q + 32'd4; wr_d = 1'b1; npc_d = {ea[31:1], 1'b0};
          end
          CL_BRANCH: begin
            case (cur_q.f3)
              F3_BEQ:  if (a == b) npc_d = pc_q + cur_q.imm;
              F3_BNE:  if (a != b) npc_d = pc_q + cur_q.imm;
              F3_BLT:  if ($signed(a) < $signed(b)) npc_d = pc_q + cur_q.imm;
              F3_BGE:  if ($signed(a) >= $signed(b)) npc_d = pc_q + cur_q.imm;
              F3_BLTU: if (a < b) npc_d = pc_q + cur_q.imm;
              F3_BGEU: if (a >= b) npc_d = pc_q + cur_q.imm;
              default: npc_d = pc_q + 32'd4;
            endcase
          end
          CL_STORE: begin
            st_en_d = (cur_q.f3 == F3_B) || (cur_q.f3 == F3_H) || (cur_q.f3 == F3_W);
            case (cur_q.f3)
              F3_B:    st_data_d = {24'd0, b[7:0]};
              F3_H:    st_data_d = {16'd0, b[15:0]};
              default: st_data_d = b;
            endcase
          end
          CL_OPIMM: begin
            wr_d = 1'b1;
            case (cur_q.f3)
              F3_ADD:  res_d = ea;
              F3_SLL:  res_d = a << cur_q.rs2;
              F3_SLT:  res_d = {31'd0, $signed(a) < $signed(cur_q.imm)};
              F3_SLTU: res_d = {31'd0, a < cur_q.imm};
              F3_XOR:  res_d = a ^ cur_q.imm;
              F3_SR:   res_d = cur_q.f7[5] ? 32'($signed(a) >>> cur_q.rs2)
                                           : a >> cur_q.rs2;
              F3_OR:   res_d = a | cur_q.imm;
              default: res_d = a & cur_q.imm;
            endcase
          end
          CL_OP: begin
            wr_d = 1'b1;
            if (cur_q.f7 == 7'd0) begin
              case (cur_q.f3)
                F3_ADD:  res_d = a + b;
                F3_SLL:  res_d = a << b[4:0];
                F3_SLT:  res_d = {31'd0, $signed(a) < $signed(b)};
                F3_SLTU: res_d = {31'd0, a < b};
                F3_XOR:  res_d = a ^ b;
                F3_SR:   res_d = a >> b[4:0];
                F3_OR:   res_d = a | b;
                default: res_d = a & b;
              endcase
            end else if (cur_q.f7 == F7_ALT && cur_q.f3 == F3_ADD) begin
              res_d = a - b;
            end else if (cur_q.f7 == F7_ALT && cur_q.f3 == F3_SR) begin
              res_d = 32'($signed(a) >>> b[4:0]);
            end else begin
              wr_d = 1'b0;
            end
          end
          CL_MULDIV: wr_d = 1'b1;
          default:   wr_d = 1'b0;
        endcase
      end
      ST_LOAD: begin
        wr_d = 1'b1;
        case (cur_q.f3)
          F3_B:    res_d = {{24{mrd[7]}}, mrd[7:0]};
          F3_H:    res_d = {{16{mrd[15]}}, mrd[15:0]};
          F3_W:    res_d = mrd;
          F3_BU:   res_d = {24'd0, mrd[7:0]};
          F3_HU:   res_d = {16'd0, mrd[15:0]};
          default: begin
            res_d = 32'd0; wr_d = 1'b0;
          end
        endcase
      end
      ST_MUL: res_d = (cur_q.f3 == F3_MUL) ? prod[31:0] : prod[63:32];
      ST_DIV: begin
        if (div_done) begin
          if (!cur_q.f3[1]) begin
            // quotient; divide by zero gives all ones
            if (opb_q == 32'd0) res_d = 32'hFFFF_FFFF;
            else if (cur_q.f3 == F3_DIV && (opa_q[31] != opb_q[31])) res_d = 32'd0 - quo;
            else res_d = quo;
          end else begin
            if (opb_q == 32'd0) res_d = opa_q;
            else if (cur_q.f3 == F3_REM && opa_q[31]) res_d = 32'd0 - rem;
            else res_d = rem;
          end
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_head_i;
    if (state_q == ST_EXEC) begin
      opa_q <= a;
      opb_q <= b;
    end
    res_q <= res_d; wr_q <= wr_d; npc_q <= npc_d; halt_q <= halt_d; ill_q <= ill_d;
    ov_q <= ov_d; och_q <= och_d; st_en_q <= st_en_d; st_addr_q <= st_addr_d;
    st_data_q <= st_data_d; mul_a_q <= mul_a_d; mul_b_q <= mul_b_d;
    if (commit) begin
      next_pc_o   <= npc_q;
      halted_o    <= halt_q;
      illegal_o   <= ill_q;
      out_valid_o <= ov_q;
      out_char_o  <= och_q;
      wb_valid_o  <= rf_we;
      wb_index_o  <= rf_we ? cur_q.rd : 5'd0;
      wb_value_o  <= rf_we ? res_q : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pc_q       <= 32'd0;
      rf_vld_q   <= 32'd0;
      clr_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy) clr_q <= clr_q + 1'b1;
      if (commit) begin
        pc_q <= npc_q;
        out_full_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_full_q <= 1'b0;
      end
      if (rf_we) rf_vld_q[cur_q.rd] <= 1'b1;
    end
  end

  assign res_valid_o = out_full_q;
endmodule

@@ rtl/core/rvx_chk.sv @@
// Port-level checker for the RV32IM execute block, bound to the top level.
module rvx_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] instr_word_i,
  input logic [7:0]  in_char_i,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic [31:0] next_pc_o,
  input logic        halted_o,
  input logic        illegal_o,
  input logic        out_valid_o,
  input logic [7:0]  out_char_o,
  input logic        wb_valid_o,
  input logic [4:0]  wb_index_o,
  input logic [31:0] wb_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(next_pc_o) && $stable(wb_value_o))
    else $error("stalled result word changed");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (halted_o || illegal_o) |-> !wb_valid_o && !out_valid_o && !(halted_o && illegal_o))
    else $error("halt or illegal word with side effects");

  a_nowb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !wb_valid_o |-> wb_index_o == 5'd0 && wb_value_o == 32'd0)
    else $error("write-back fields set without write");

  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && wb_valid_o |-> wb_index_o != 5'd0 && !out_valid_o)
    else $error("write-back to x0 or together with char output");
endmodule

bind rv32im_instruction_execute rvx_chk u_rvx_chk (.*);
